/* src/sorted_matrix_staircase_search_top_defines.svh */
// Assertion macros for the staircase search block.
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_TOP_DEFINES_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_TOP_DEFINES_SVH

// Checked outside reset.
`define SMS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sms: check failed");

// Checked on every edge, reset included.
`define SMS_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("sms: check failed");

`endif

/* src/sms_pkg.sv */
// Shared types and constants for the staircase search block.
package sms_pkg;

   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int ROW_FIELD_W = 6;
   localparam int COL_FIELD_W = 6;
   localparam int FIELD_W     = 32;
   localparam int COUNT_W     = 13;
   localparam int TOTAL_W     = 2 * CFG_W;
   localparam int KIND_W      = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_USED_W  = 1 + ROW_FIELD_W + COL_FIELD_W + COUNT_W;

   localparam logic [CFG_W-1:0]   CFG_RESET = 7'd64;
   localparam logic [TOTAL_W-1:0] COUNT_MAX = 14'd8191;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd1;

   typedef enum logic [1:0] {
      WS_IDLE,
      WS_WALK,
      WS_DONE
   } walk_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } walk_status_type;

   typedef struct packed {
      logic [COUNT_W-1:0]     at_most_count;
      logic [COL_FIELD_W-1:0] match_col;
      logic [ROW_FIELD_W-1:0] match_row;
      logic                   found;
   } walk_result_type;

endpackage

/* src/sms_mem.sv */
// Matrix cell store: one write port, one registered read port.
module sms_mem #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sms_walk.sv */
// Staircase walker: steps one row or column per cycle through the cell store.
module sms_walk #(
   parameter int MAX_COLS    = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int ADDR_W      = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           start_count,
   input  logic [VALUE_WIDTH-1:0]         start_key,
   input  logic [sms_pkg::CFG_W-1:0]      rows_eff,
   input  logic [sms_pkg::CFG_W-1:0]      cols_eff,
   input  logic                           res_ready,
   output sms_pkg::walk_status_type       status,
   output sms_pkg::walk_result_type       result,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr,
   input  logic [VALUE_WIDTH-1:0]         rd_data
);
   import sms_pkg::*;

   walk_state_type             state_ff, state_in;
   logic                       count_mode_ff, count_mode_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [CFG_W-1:0]           r_ff, r_in;
   logic [CFG_W-1:0]           c_ff, c_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic [TOTAL_W-1:0]         total_ff, total_in;
   logic                       found_ff, found_in;
   logic [ROW_FIELD_W-1:0]     mrow_ff, mrow_in;
   logic [COL_FIELD_W-1:0]     mcol_ff, mcol_in;
   logic signed [VALUE_WIDTH-1:0] cell_val;
   logic [CFG_W-1:0]           c_dec;
   logic                       hit;

   assign cell_val = signed'(rd_data);
   assign c_dec    = c_ff - CFG_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_mode_ff <= count_mode_in;
      key_ff        <= key_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      addr_ff       <= addr_in;
      total_ff      <= total_in;
      found_ff      <= found_in;
      mrow_ff       <= mrow_in;
      mcol_ff       <= mcol_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_mode_in = count_mode_ff;
      key_in        = key_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      addr_in       = addr_ff;
      total_in      = total_ff;
      found_in      = found_ff;
      mrow_in       = mrow_ff;
      mcol_in       = mcol_ff;
      hit           = 1'b0;
      rd_en         = 1'b0;
      case (state_ff)
         WS_IDLE: begin
            if (start) begin
               count_mode_in = start_count;
               key_in        = signed'(start_key);
               r_in          = '0;
               c_in          = cols_eff;
               addr_in       = ADDR_W'(cols_eff) - ADDR_W'(1);
               total_in      = '0;
               found_in      = 1'b0;
               mrow_in       = '0;
               mcol_in       = '0;
               if (rows_eff != '0 && cols_eff != '0) begin
                  rd_en    = 1'b1;
                  state_in = WS_WALK;
               end else begin
                  state_in = WS_DONE;
               end
            end
         end
         WS_WALK: begin
            // rd_data holds the cell at (r, c-1)
            if (count_mode_ff) begin
               if (key_ff < cell_val) begin
                  c_in    = c_dec;
                  addr_in = addr_ff - ADDR_W'(1);
               end else begin
                  total_in = total_ff + TOTAL_W'(c_ff);
                  r_in     = r_ff + CFG_W'(1);
                  addr_in  = addr_ff + ADDR_W'(MAX_COLS);
               end
            end else begin
               if (cell_val < key_ff) begin
                  r_in    = r_ff + CFG_W'(1);
                  addr_in = addr_ff + ADDR_W'(MAX_COLS);
               end else if (key_ff < cell_val) begin
                  c_in    = c_dec;
                  addr_in = addr_ff - ADDR_W'(1);
               end else begin
                  hit      = 1'b1;
                  found_in = 1'b1;
                  mrow_in  = r_ff[ROW_FIELD_W-1:0];
                  mcol_in  = c_dec[COL_FIELD_W-1:0];
               end
            end
            if (!hit && r_in < rows_eff && c_in != '0) begin
               rd_en = 1'b1;
            end else begin
               state_in = WS_DONE;
            end
         end
         WS_DONE: begin
            if (res_ready) begin
               state_in = WS_IDLE;
            end
         end
         default: begin
            state_in = WS_IDLE;
         end
      endcase
   end

   assign rd_addr = addr_in;

   assign status.idle = (state_ff == WS_IDLE);
   assign status.done = (state_ff == WS_DONE);

   assign result.found         = found_ff;
   assign result.match_row     = mrow_ff;
   assign result.match_col     = mcol_ff;
   assign result.at_most_count = (total_ff > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                                        : total_ff[COUNT_W-1:0];

endmodule

/* src/sorted_matrix_staircase_search_top.sv */
// Top level of the sorted-matrix staircase search block.
`include "sorted_matrix_staircase_search_top_defines.svh"

// Holds a row- and column-sorted matrix of signed cells in one synchronous RAM.
// A write request (tuser 0) stores one cell and gives no response. A search
// (tuser 1) walks from the top-right corner of the area in use and returns
// found with the row and column of a match; a count (tuser 2) returns how many
// cells are at most the key. A query makes one RAM read per step and at most
// rows_in_use + cols_in_use - 1 reads, so at most 127 for a full 64 x 64 area;
// all of them go through the single RAM read port.
// One query is in flight at a time; a finished response sits in an output
// register, so the next request is taken while it waits. The store is not
// cleared at reset: a cell must be written before any query reaches it.
// Register 0 is rows_in_use, register 1 is cols_in_use (both reset to 64,
// values above the maximum act as the maximum). tuser 3 is accepted and dropped.
module sorted_matrix_staircase_search_top #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cell_row[5:0], cell_col[11:6], cell_value[43:12] (signed),
   // search_key[75:44] (signed), zero fill [79:76]
   input  logic [sms_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // kind[1:0]
   input  logic [sms_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found[0], match_row[6:1], match_col[12:7], at_most_count[25:13],
   // zero fill [31:26]
   output logic [sms_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [sms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sms_pkg::CFG_W-1:0]         csr_wdata
);
   import sms_pkg::*;

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CFG_W-1:0]        rows_ff, rows_in;
   logic [CFG_W-1:0]        cols_ff, cols_in;
   logic [CFG_W-1:0]        rows_eff, cols_eff;
   logic                    rsp_valid_ff, rsp_valid_in;
   walk_result_type         rsp_data_ff, rsp_data_in;

   logic [ROW_FIELD_W-1:0]  cell_row;
   logic [COL_FIELD_W-1:0]  cell_col;
   logic [FIELD_W-1:0]      cell_value;
   logic [FIELD_W-1:0]      search_key;
   logic [63:0]             value_ext, key_ext;

   logic                    req_fire;
   logic                    start, start_count;
   logic                    mem_wr_en;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [VALUE_WIDTH-1:0]  rd_data;
   logic                    push;
   walk_status_type         walk_status;
   walk_result_type         walk_result;

   assign cell_row   = req_tdata[5:0];
   assign cell_col   = req_tdata[11:6];
   assign cell_value = req_tdata[43:12];
   assign search_key = req_tdata[75:44];

   // stored cells are the low VALUE_WIDTH bits of the sign-extended field
   assign value_ext = {{32{cell_value[FIELD_W-1]}}, cell_value};
   assign key_ext   = {{32{search_key[FIELD_W-1]}}, search_key};

   // ---------------- configuration ----------------
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in = csr_wdata;
            CSR_COLS_IN_USE: cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_RESET;
         cols_ff <= CFG_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign rows_eff = (int'(rows_ff) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (int'(cols_ff) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_ff;

   // ---------------- request decode ----------------
   assign req_tready  = walk_status.idle;
   assign req_fire    = req_tvalid && req_tready;
   assign start       = req_fire && (req_tuser inside {KIND_SEARCH, KIND_COUNT});
   assign start_count = (req_tuser == KIND_COUNT);
   assign mem_wr_en   = req_fire && (req_tuser == KIND_WRITE)
                        && (int'(cell_row) < MAX_ROWS) && (int'(cell_col) < MAX_COLS);
   assign mem_wr_addr = ADDR_W'(int'(cell_row) * MAX_COLS + int'(cell_col));

   sms_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (value_ext[VALUE_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sms_walk #(
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_count (start_count),
      .start_key   (key_ext[VALUE_WIDTH-1:0]),
      .rows_eff    (rows_eff),
      .cols_eff    (cols_eff),
      .res_ready   (push),
      .status      (walk_status),
      .result      (walk_result),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   // ---------------- response register ----------------
   assign push = walk_status.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = walk_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_data_ff};

   // ---------------- checks ----------------
   `SMS_ASSERT(a_push_no_overwrite, push |-> (!rsp_valid_ff || rsp_tready))
   `SMS_ASSERT(a_write_only_idle, mem_wr_en |-> walk_status.idle)
   `SMS_ASSERT(a_found_has_no_count,
      rsp_tvalid |-> !(rsp_data_ff.found && rsp_data_ff.at_most_count != '0))
   `SMS_ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) && !reset |-> !rsp_tvalid)

endmodule
